// File: rtl/stxl_pkg.sv
package stxl_pkg;

  localparam int CHAN_W = 8;
  localparam int XYZ_W = 7;
  localparam int COEF_W = 14;

  localparam logic [COEF_W-1:0] M_XR = 14'd4124;
  localparam logic [COEF_W-1:0] M_XG = 14'd3576;
  localparam logic [COEF_W-1:0] M_XB = 14'd1805;
  localparam logic [COEF_W-1:0] M_YR = 14'd2126;
  localparam logic [COEF_W-1:0] M_YG = 14'd7152;
  localparam logic [COEF_W-1:0] M_YB = 14'd722;
  localparam logic [COEF_W-1:0] M_ZR = 14'd193;
  localparam logic [COEF_W-1:0] M_ZG = 14'd1192;
  localparam logic [COEF_W-1:0] M_ZB = 14'd9505;

  // Quotients by 100 are formed as (q * 5243) >> 19, exact for q below 43690.
  localparam int DIV100_RECIP = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_PROD_W = 27;

  localparam int L_MAX = 100;
  localparam int AB_MAX = 127;
  localparam int AB_MIN_MAG = 128;

  typedef enum logic [1:0] {
    WHITE_X = 2'd0,
    WHITE_Y = 2'd1,
    WHITE_Z = 2'd2
  } white_t;

  function automatic longint unsigned pow_q30(input longint unsigned r, input int k);
    longint unsigned p;
    p = r;
    for (int i = 1; i < k; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  function automatic longint unsigned root_q30(input longint unsigned s, input int k);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (pow_q30(mid, k) <= s) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  function automatic longint unsigned q30_to_qf(input longint unsigned v, input int frac);
    int sh;
    sh = 30 - frac;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic longint unsigned gamma_qf(input longint unsigned c, input int frac);
    longint unsigned num;
    longint unsigned n;
    longint unsigned s;
    longint unsigned r;
    if (c <= 64'd10) begin
      num = (c * 64'd25) << frac;
      return num / 64'd82365 + (((num % 64'd82365) * 64'd2 >= 64'd82365) ? 64'd1 : 64'd0);
    end
    n = 64'd40 * c + 64'd561;
    s = ((n * n) << 30) / 64'd115799121;
    r = root_q30(s, 5);
    return q30_to_qf((s * r) >> 30, frac);
  endfunction

  function automatic longint unsigned lab_f_qf(input longint unsigned n, input white_t sel,
                                               input int frac);
    longint unsigned t;
    if (n == 64'd0) begin
      return ((64'd16 << frac) + 64'd58) / 64'd116;
    end
    unique case (sel)
      WHITE_X: t = ((n * 64'd1000) << 30) / 64'd95047;
      WHITE_Y: t = (n << 30) / 64'd100;
      WHITE_Z: t = ((n * 64'd1000) << 30) / 64'd108883;
      default: t = 64'd0;
    endcase
    return q30_to_qf(root_q30(t, 3), frac);
  endfunction

endpackage

// File: rtl/stxl_sat.sv
module stxl_sat #(
  parameter int WIDTH = 27,
  parameter int FRAC = 16,
  parameter bit LUMA = 1'b0
) (
  input  logic signed [WIDTH-1:0] value,
  output logic signed [7:0]       result
);

  localparam int MW = WIDTH - FRAC;

  logic [WIDTH-1:0] mag;
  logic [MW-1:0]    whole;
  logic             neg;

  always_comb begin
    neg = value[WIDTH-1];
    mag = neg ? WIDTH'(-value) : WIDTH'(value);
    whole = mag[WIDTH-1:FRAC];
    if (LUMA) begin
      if (neg) begin
        result = 8'sd0;
      end else if (whole > MW'(stxl_pkg::L_MAX)) begin
        result = 8'(stxl_pkg::L_MAX);
      end else begin
        result = 8'(whole);
      end
    end else begin
      if (neg) begin
        if (whole > MW'(stxl_pkg::AB_MIN_MAG)) begin
          result = 8'(-stxl_pkg::AB_MIN_MAG);
        end else begin
          result = 8'(-8'(whole));
        end
      end else if (whole > MW'(stxl_pkg::AB_MAX)) begin
        result = 8'(stxl_pkg::AB_MAX);
      end else begin
        result = 8'(whole);
      end
    end
  end

endmodule

// File: rtl/srgb_to_xyz_lab.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    mode, red, green, blue
// output    out        out_valid/out_ready  first_component, second_component, third_component
//
// Each item passes through eight register stages: gamma table, matrix products, row sums,
// divide by 100, f() tables, differences, scaling, then truncation and saturation.
// One item may enter every cycle unless every stage is full and out_ready is low.
// Synchronous reset clears only the stage valid bits.
// Each stage holds while the stage after it is full and stalled, so a stall loses nothing.
module srgb_to_xyz_lab #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        first_component,
  output logic signed [7:0] second_component,
  output logic signed [7:0] third_component
);

  localparam int F = COEF_FRAC_BITS;
  localparam int GW = F + 1;
  localparam int PW = GW + stxl_pkg::COEF_W;
  localparam int SW = PW + 2;
  localparam int QW = 14;
  localparam int XW = stxl_pkg::XYZ_W;
  localparam int DW = F + 2;
  localparam int AW = F + 11;
  localparam int NS = 8;
  localparam int GAMMA_DEPTH = 1 << stxl_pkg::CHAN_W;
  localparam int F_DEPTH = 1 << XW;

  localparam logic signed [AW-1:0] K116 = AW'(116);
  localparam logic signed [AW-1:0] K500 = AW'(500);
  localparam logic signed [AW-1:0] K200 = AW'(200);
  localparam logic signed [AW-1:0] L_OFFSET = AW'(16) <<< F;

  logic [GW-1:0] gamma_rom [GAMMA_DEPTH];
  logic [GW-1:0] fx_rom [F_DEPTH];
  logic [GW-1:0] fy_rom [F_DEPTH];
  logic [GW-1:0] fz_rom [F_DEPTH];

  for (genvar i = 0; i < GAMMA_DEPTH; i++) begin : g_gamma
    assign gamma_rom[i] = GW'(stxl_pkg::gamma_qf(i, F));
  end

  for (genvar i = 0; i < F_DEPTH; i++) begin : g_ftab
    assign fx_rom[i] = GW'(stxl_pkg::lab_f_qf(i, stxl_pkg::WHITE_X, F));
    assign fy_rom[i] = GW'(stxl_pkg::lab_f_qf(i, stxl_pkg::WHITE_Y, F));
    assign fz_rom[i] = GW'(stxl_pkg::lab_f_qf(i, stxl_pkg::WHITE_Z, F));
  end

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: gamma linearization.
  logic          mode1;
  logic [GW-1:0] gr1, gg1, gb1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mode1 <= mode;
      gr1 <= gamma_rom[red];
      gg1 <= gamma_rom[green];
      gb1 <= gamma_rom[blue];
    end
  end

  // Stage 2: matrix products.
  logic          mode2;
  logic [PW-1:0] pxr, pxg, pxb, pyr, pyg, pyb, pzr, pzg, pzb;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      mode2 <= mode1;
      pxr <= PW'(gr1) * PW'(stxl_pkg::M_XR);
      pxg <= PW'(gg1) * PW'(stxl_pkg::M_XG);
      pxb <= PW'(gb1) * PW'(stxl_pkg::M_XB);
      pyr <= PW'(gr1) * PW'(stxl_pkg::M_YR);
      pyg <= PW'(gg1) * PW'(stxl_pkg::M_YG);
      pyb <= PW'(gb1) * PW'(stxl_pkg::M_YB);
      pzr <= PW'(gr1) * PW'(stxl_pkg::M_ZR);
      pzg <= PW'(gg1) * PW'(stxl_pkg::M_ZG);
      pzb <= PW'(gb1) * PW'(stxl_pkg::M_ZB);
    end
  end

  // Stage 3: row sums, scaled down by 2^F.
  logic          mode3;
  logic [SW-1:0] sx, sy, sz;
  logic [QW-1:0] qx3, qy3, qz3;

  always_comb begin
    sx = SW'(pxr) + SW'(pxg) + SW'(pxb);
    sy = SW'(pyr) + SW'(pyg) + SW'(pyb);
    sz = SW'(pzr) + SW'(pzg) + SW'(pzb);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      mode3 <= mode2;
      qx3 <= sx[F+QW-1:F];
      qy3 <= sy[F+QW-1:F];
      qz3 <= sz[F+QW-1:F];
    end
  end

  // Stage 4: divide by 100.
  logic                             mode4;
  logic [XW-1:0]                    x4, y4, z4;
  logic [stxl_pkg::DIV100_PROD_W-1:0] mx, my, mz;

  always_comb begin
    mx = stxl_pkg::DIV100_PROD_W'(qx3) * stxl_pkg::DIV100_PROD_W'(stxl_pkg::DIV100_RECIP);
    my = stxl_pkg::DIV100_PROD_W'(qy3) * stxl_pkg::DIV100_PROD_W'(stxl_pkg::DIV100_RECIP);
    mz = stxl_pkg::DIV100_PROD_W'(qz3) * stxl_pkg::DIV100_PROD_W'(stxl_pkg::DIV100_RECIP);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      mode4 <= mode3;
      x4 <= mx[stxl_pkg::DIV100_SHIFT+XW-1:stxl_pkg::DIV100_SHIFT];
      y4 <= my[stxl_pkg::DIV100_SHIFT+XW-1:stxl_pkg::DIV100_SHIFT];
      z4 <= mz[stxl_pkg::DIV100_SHIFT+XW-1:stxl_pkg::DIV100_SHIFT];
    end
  end

  // Stage 5: f() tables.
  logic          mode5;
  logic [XW-1:0] x5, y5, z5;
  logic [GW-1:0] fx5, fy5, fz5;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      mode5 <= mode4;
      x5 <= x4;
      y5 <= y4;
      z5 <= z4;
      fx5 <= fx_rom[x4];
      fy5 <= fy_rom[y4];
      fz5 <= fz_rom[z4];
    end
  end

  // Stage 6: differences.
  logic                 mode6;
  logic [XW-1:0]        x6, y6, z6;
  logic signed [DW-1:0] fl6, dxy6, dyz6;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      mode6 <= mode5;
      x6 <= x5;
      y6 <= y5;
      z6 <= z5;
      fl6 <= $signed({1'b0, fy5});
      dxy6 <= $signed({1'b0, fx5}) - $signed({1'b0, fy5});
      dyz6 <= $signed({1'b0, fy5}) - $signed({1'b0, fz5});
    end
  end

  // Stage 7: scaling into L, a and b in Q(F).
  logic                 mode7;
  logic [XW-1:0]        x7, y7, z7;
  logic signed [AW-1:0] l7, a7, b7;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      mode7 <= mode6;
      x7 <= x6;
      y7 <= y6;
      z7 <= z6;
      l7 <= AW'(fl6) * K116 - L_OFFSET;
      a7 <= AW'(dxy6) * K500;
      b7 <= AW'(dyz6) * K200;
    end
  end

  // Stage 8: truncation, saturation and output select.
  logic signed [7:0] l_sat, a_sat, b_sat;

  stxl_sat #(.WIDTH(AW), .FRAC(F), .LUMA(1'b1)) u_sat_l (.value(l7), .result(l_sat));
  stxl_sat #(.WIDTH(AW), .FRAC(F), .LUMA(1'b0)) u_sat_a (.value(a7), .result(a_sat));
  stxl_sat #(.WIDTH(AW), .FRAC(F), .LUMA(1'b0)) u_sat_b (.value(b7), .result(b_sat));

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      if (mode7) begin
        first_component <= l_sat[6:0];
        second_component <= a_sat;
        third_component <= b_sat;
      end else begin
        first_component <= x7;
        second_component <= $signed({1'b0, y7});
        third_component <= $signed({1'b0, z7});
      end
    end
  end

endmodule
